>>> sv/led_brightness_ramp_limiter_assert.svh
// Assertion macros for the ramp limiter.
// LBRL_ASSERT is checked outside reset; LBRL_ASSERT_ALWAYS also during reset.
`ifndef LED_BRIGHTNESS_RAMP_LIMITER_ASSERT_SVH
`define LED_BRIGHTNESS_RAMP_LIMITER_ASSERT_SVH

`ifndef ASSERT_OFF
`define LBRL_ASSERT(name, clk, rst_n, prop) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("ramp limiter assertion failed");
`define LBRL_ASSERT_ALWAYS(name, clk, prop) \
	name: assert property (@(posedge clk) prop) \
		else $error("ramp limiter assertion failed");
`else
`define LBRL_ASSERT(name, clk, rst_n, prop)
`define LBRL_ASSERT_ALWAYS(name, clk, prop)
`endif

`endif

>>> sv/lbrl_pkg.sv
package lbrl_pkg;

	localparam logic [15:0] MAX_LEVEL       = 16'd255;
	localparam logic [31:0] STEP_RATE_RESET = 32'h0001_0000;
	localparam int          FRAC_BITS       = 16;
	localparam logic [63:0] PRODUCT_CAP     = 64'h0000_0100_0000_0000;
	localparam logic [32:0] ROUND_HALF      = 33'h0_0000_8000;

	typedef enum logic [1:0] {
		OP_TICK       = 2'd0,
		OP_SET_TARGET = 2'd1,
		OP_SET_NOW    = 2'd2
	} op_t;

	// fraction_carry is signed Q0.16 in [-0.5, 0.5)
	typedef struct packed {
		logic [15:0] current_level;
		logic [15:0] target_level;
		logic [16:0] fraction_carry;
		logic [31:0] last_step_time;
	} ramp_state_t;

	function automatic logic [15:0] clamp_level(input logic [15:0] v);
		return (v > MAX_LEVEL) ? MAX_LEVEL : v;
	endfunction

endpackage

>>> sv/lbrl_if.sv
interface lbrl_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [15:0] level_value;
	logic [31:0] now_ms;

	modport source (output valid, output op, output level_value, output now_ms, input ready);
	modport sink   (input valid, input op, input level_value, input now_ms, output ready);
endinterface

interface lbrl_res_if;
	logic        valid;
	logic        ready;
	logic [15:0] brightness;
	logic        at_target;

	modport source (output valid, output brightness, output at_target, input ready);
	modport sink   (input valid, input brightness, input at_target, output ready);
endinterface

>>> sv/led_brightness_ramp_limiter.sv
// LED brightness ramp limiter.
// cmd channel (valid/ready): op, level_value, now_ms. One transaction in gives
// exactly one transaction out on the result channel: brightness and at_target.
// cfg_wr_en/cfg_wr_data write step_rate (unsigned Q16.16 steps per ms); write
// it only while no transaction is in flight.
// A command accepted passes through the input register, then the result
// register, where it is shown on result; a result stall holds it in between.
// Throughput: one transaction per cycle while result.ready does not stall.
// The tick path between the input register and the state/result registers
// is combinational: elapsed-time subtract, 32x32 multiply, add, clamp, round.
// Reset: step_rate = 1.0, level, target, carry and last step time all zero;
// no result pending.
// Receiver stall: the result register holds its transaction, the input
// register holds one more command, then cmd.ready drops until result.ready.
`include "led_brightness_ramp_limiter_assert.svh"

module led_brightness_ramp_limiter
	import lbrl_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	lbrl_cmd_if.sink    cmd,
	lbrl_res_if.source  result,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data
);

	logic [31:0] step_rate_q;
	logic        valid_s1;
	logic [1:0]  op_s1;
	logic [15:0] level_s1;
	logic [31:0] now_s1;
	ramp_state_t state_q;
	ramp_state_t state_nxt;
	ramp_state_t tick_nxt;
	logic        res_valid_q;
	logic [15:0] brightness_q;
	logic        at_target_q;
	logic        advance;
	logic [15:0] lv_clamped;

	assign advance   = valid_s1 && (!res_valid_q || result.ready);
	assign cmd.ready = !valid_s1 || advance;

	assign result.valid      = res_valid_q;
	assign result.brightness = brightness_q;
	assign result.at_target  = at_target_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_rate_q <= STEP_RATE_RESET;
		end else if (cfg_wr_en) begin
			step_rate_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.ready && cmd.valid) begin
			op_s1    <= cmd.op;
			level_s1 <= cmd.level_value;
			now_s1   <= cmd.now_ms;
		end
	end

	lbrl_tick u_tick (
		.st        (state_q),
		.step_rate (step_rate_q),
		.now_ms    (now_s1),
		.nxt       (tick_nxt)
	);

	assign lv_clamped = clamp_level(level_s1);

	always_comb begin
		state_nxt = state_q;
		case (op_t'(op_s1))
			OP_TICK: begin
				state_nxt = tick_nxt;
			end
			OP_SET_TARGET: begin
				// raw request compared, not the clamped one
				if (level_s1 != state_q.target_level) begin
					state_nxt.target_level   = lv_clamped;
					state_nxt.fraction_carry = 17'd0;
					state_nxt.last_step_time = now_s1;
				end
			end
			OP_SET_NOW: begin
				state_nxt.target_level  = lv_clamped;
				state_nxt.current_level = lv_clamped;
			end
			default: begin
				state_nxt = state_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			brightness_q <= state_nxt.current_level;
			at_target_q  <= (state_nxt.current_level == state_nxt.target_level);
		end
	end

	`LBRL_ASSERT(a_result_tracks_state, clk, arst_n, advance |=> (brightness_q == state_q.current_level && at_target_q == (state_q.current_level == state_q.target_level)))
	`LBRL_ASSERT(a_level_capped, clk, arst_n, res_valid_q |-> brightness_q <= MAX_LEVEL)
	`LBRL_ASSERT(a_stalled_cmd_kept, clk, arst_n, (valid_s1 && !advance) |=> valid_s1)
	`LBRL_ASSERT(a_target_capped, clk, arst_n, state_q.target_level <= MAX_LEVEL)
	`LBRL_ASSERT(a_carry_in_range, clk, arst_n, state_q.fraction_carry[16] == state_q.fraction_carry[15])

endmodule

>>> sv/lbrl_tick.sv
module lbrl_tick
	import lbrl_pkg::*;
(
	input  ramp_state_t st,
	input  logic [31:0] step_rate,
	input  logic [31:0] now_ms,
	output ramp_state_t nxt
);

	logic [31:0]        elapsed;
	logic [63:0]        prod;
	logic [40:0]        prod_sat;
	logic               up;
	logic [15:0]        lower;
	logic [15:0]        upper;
	logic signed [42:0] cur_fx;
	logic signed [42:0] carry_ext;
	logic signed [42:0] prod_s;
	logic signed [42:0] ideal;
	logic signed [42:0] lo_fx;
	logic signed [42:0] hi_fx;
	logic signed [42:0] ideal_c;
	logic [32:0]        rounded;
	logic [15:0]        new_level;
	logic [16:0]        new_carry;

	assign elapsed  = now_ms - st.last_step_time;
	assign prod     = {32'd0, elapsed} * {32'd0, step_rate};
	assign prod_sat = (prod > PRODUCT_CAP) ? PRODUCT_CAP[40:0] : prod[40:0];

	assign up    = st.current_level < st.target_level;
	assign lower = up ? st.current_level : st.target_level;
	assign upper = up ? st.target_level : st.current_level;

	assign cur_fx    = $signed({11'd0, st.current_level, 16'd0});
	assign carry_ext = $signed({{26{st.fraction_carry[16]}}, st.fraction_carry});
	assign prod_s    = $signed({2'd0, prod_sat});
	assign ideal     = up ? (cur_fx + carry_ext + prod_s) : (cur_fx + carry_ext - prod_s);

	assign lo_fx = $signed({11'd0, lower, 16'd0});
	assign hi_fx = $signed({11'd0, upper, 16'd0});

	always_comb begin
		if (ideal > hi_fx) begin
			ideal_c = hi_fx;
		end else if (ideal <= lo_fx) begin
			ideal_c = lo_fx;
		end else begin
			ideal_c = ideal;
		end
	end

	// clamped value lies in [0, 2^32); round half up, keep the excess
	assign rounded   = {1'b0, ideal_c[31:0]} + ROUND_HALF;
	assign new_level = rounded[FRAC_BITS +: 16];
	assign new_carry = ideal_c[16:0] - {new_level[0], 16'd0};

	always_comb begin
		nxt = st;
		if (st.current_level != st.target_level && elapsed != 32'd0) begin
			nxt.current_level  = new_level;
			nxt.fraction_carry = new_carry;
			nxt.last_step_time = now_ms;
		end
	end

endmodule

>>> tb/led_brightness_ramp_limiter_tb.sv
`timescale 1ns / 1ps

module led_brightness_ramp_limiter_tb;
	import lbrl_pkg::*;

	localparam logic [1:0] OP_UNUSED  = 2'd3;
	localparam int         STALL_LIMIT = 4000;
	localparam int         PHASE_ITEMS = 272;

	typedef struct packed {
		logic [15:0] brightness;
		logic        at_target;
	} lamp_out_t;

	// Shadow of the ramp state; one predicted lamp output per command.
	class ramp_scoreboard;
		bit [31:0]  rate;
		bit [15:0]  cur;
		bit [15:0]  tgt;
		bit [16:0]  carry;
		bit [31:0]  last_ms;
		lamp_out_t  lamp_q[$];
		int         errors;
		int         checked;
		int         ramp_steps;
		int         capped_steps;

		function new();
			rate    = STEP_RATE_RESET;
			cur     = '0;
			tgt     = '0;
			carry   = '0;
			last_ms = '0;
		endfunction

		function bit [15:0] limit_level(bit [15:0] v);
			return (v > MAX_LEVEL) ? MAX_LEVEL : v;
		endfunction

		function void advance_ramp(bit [31:0] now);
			bit [31:0]    elapsed;
			bit [63:0]    prod;
			longint       ideal;
			longint       lo;
			longint       hi;
			longint       carry_s;
			bit [31:0]    lvl;
			bit           up;
			if (cur == tgt)
				return;
			elapsed = now - last_ms;
			if (elapsed == 0)
				return;
			last_ms = now;
			up = cur < tgt;
			prod = 64'(elapsed) * 64'(rate);
			if (prod > PRODUCT_CAP) begin
				prod = PRODUCT_CAP;
				capped_steps++;
			end
			carry_s = carry;
			if (carry[16])
				carry_s -= 64'sh2_0000;
			ideal = longint'(cur) * 65536 + carry_s;
			if (up)
				ideal += longint'(prod);
			else
				ideal -= longint'(prod);
			lo = longint'(up ? cur : tgt) * 65536;
			hi = longint'(up ? tgt : cur) * 65536;
			if (ideal > hi)
				ideal = hi;
			else if (ideal <= lo)
				ideal = lo;
			lvl = 32'((ideal + 32768) >>> FRAC_BITS);
			carry = 17'(ideal - longint'(lvl) * 65536);
			cur = lvl[15:0];
			ramp_steps++;
		endfunction

		function void note_command(logic [1:0] op, logic [15:0] lv, logic [31:0] now);
			lamp_out_t o;
			case (op)
				OP_TICK: begin
					advance_ramp(now);
				end
				OP_SET_TARGET: begin
					// raw value compared, so an out-of-range repeat still restamps
					if (lv != tgt) begin
						tgt = limit_level(lv);
						carry = '0;
						last_ms = now;
					end
				end
				OP_SET_NOW: begin
					tgt = limit_level(lv);
					cur = tgt;
				end
				default: ;
			endcase
			o.brightness = cur;
			o.at_target  = (cur == tgt);
			lamp_q.push_back(o);
		endfunction

		function void check_result(logic [15:0] brightness, logic at_target);
			lamp_out_t w;
			if (lamp_q.size() == 0) begin
				$display("%0t: unexpected result transaction, got brightness %0d at_target %0b",
					$time, brightness, at_target);
				errors++;
				return;
			end
			w = lamp_q.pop_front();
			checked++;
			if (brightness !== w.brightness) begin
				$display("%0t: brightness mismatch, expected %0d, got %0d",
					$time, w.brightness, brightness);
				errors++;
			end
			if (at_target !== w.at_target) begin
				$display("%0t: at_target mismatch, expected %0b, got %0b",
					$time, w.at_target, at_target);
				errors++;
			end
		endfunction

		function int pending();
			return lamp_q.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;

	lbrl_cmd_if cmd_ch();
	lbrl_res_if res_ch();

	led_brightness_ramp_limiter uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd_ch),
		.result      (res_ch),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	ramp_scoreboard sb;
	int             send_idle_pct;
	int             sink_idle_pct;
	int             items_sent;
	int             stall_cycles;
	bit [31:0]      clock_ms;

	initial clk = 1'b0;
	always #4 clk = ~clk;

	always @(negedge clk) begin
		res_ch.ready <= ($urandom_range(0, 99) >= sink_idle_pct);
	end

	// Transactions are taken at the rising edge; the watchdog counts dead cycles.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cmd_ch.valid && cmd_ch.ready)
				sb.note_command(cmd_ch.op, cmd_ch.level_value, cmd_ch.now_ms);
			if (res_ch.valid && res_ch.ready)
				sb.check_result(res_ch.brightness, res_ch.at_target);
			if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// All tasks start and end just after a falling edge.
	task automatic send_cmd(input logic [1:0] op, input logic [15:0] lv, input logic [31:0] now);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid       <= 1'b1;
		cmd_ch.op          <= op;
		cmd_ch.level_value <= lv;
		cmd_ch.now_ms      <= now;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	task automatic wait_drained();
		cmd_ch.valid <= 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		// let the design sit quiet before moving on
		repeat (4) @(negedge clk);
	endtask

	task automatic write_rate(input logic [31:0] v);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		sb.rate = v;
	endtask

	function automatic bit [31:0] step_ms();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return $urandom_range(0, 3);
		else if (r < 85)
			return $urandom_range(4, 400);
		else if (r < 95)
			return $urandom_range(0, 1 << 20);
		return $urandom;
	endfunction

	function automatic bit [15:0] pick_level();
		if ($urandom_range(0, 99) < 75)
			return 16'($urandom_range(0, 300));
		return 16'($urandom);
	endfunction

	// Mostly a new target followed by a run of ticks; the rest jumps, repeats and noise.
	task automatic ramp_burst();
		int r;
		int n;
		r = $urandom_range(0, 99);
		if (r < 70) begin
			clock_ms += step_ms();
			send_cmd(OP_SET_TARGET, pick_level(), clock_ms);
			n = $urandom_range(3, 40);
			repeat (n) begin
				clock_ms += step_ms();
				send_cmd(OP_TICK, 16'($urandom), clock_ms);
			end
		end else if (r < 80) begin
			clock_ms += step_ms();
			send_cmd(OP_SET_NOW, pick_level(), clock_ms);
		end else if (r < 88) begin
			clock_ms += step_ms();
			send_cmd(OP_SET_TARGET, sb.tgt, clock_ms);
		end else if (r < 94) begin
			send_cmd(OP_UNUSED, 16'($urandom), $urandom);
		end else begin
			clock_ms += $urandom;
			send_cmd(OP_TICK, 16'($urandom), clock_ms);
		end
	endtask

	initial begin
		bit [31:0] rates[6];
		sb = new();
		cmd_ch.valid       = 1'b0;
		cmd_ch.op          = OP_TICK;
		cmd_ch.level_value = '0;
		cmd_ch.now_ms      = '0;
		res_ch.ready       = 1'b0;
		cfg_wr_en          = 1'b0;
		cfg_wr_data        = '0;
		arst_n             = 1'b0;
		send_idle_pct      = 0;
		sink_idle_pct      = 0;
		items_sent         = 0;
		stall_cycles       = 0;
		clock_ms           = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed, at the reset rate of one level per ms
		send_cmd(OP_TICK,       16'd0,      32'd5);         // tick while at target
		send_cmd(OP_UNUSED,     16'hFFFF,   32'hFFFF_FFFF); // unused op, ignored
		send_cmd(OP_SET_TARGET, 16'hFFFF,   32'd10);        // clamped to MAX_LEVEL
		send_cmd(OP_TICK,       16'd0,      32'd10);        // no time elapsed
		send_cmd(OP_TICK,       16'd0,      32'd11);
		send_cmd(OP_TICK,       16'hFFFF,   32'd20);
		send_cmd(OP_SET_TARGET, 16'hFFFF,   32'd25);        // raw differs from clamped target
		send_cmd(OP_SET_TARGET, 16'd255,    32'd30);        // same target, no restamp
		send_cmd(OP_TICK,       16'd0,      32'h0000_0200); // overshoot, clamps at target
		send_cmd(OP_TICK,       16'd0,      32'h0000_0300); // at target, time not stamped
		send_cmd(OP_SET_TARGET, 16'd0,      32'hFFFF_FFF0);
		send_cmd(OP_TICK,       16'd0,      32'h0000_0005); // elapsed across the wrap
		send_cmd(OP_SET_NOW,    16'd100,    32'h0000_0006);
		send_cmd(OP_SET_NOW,    16'hFFFF,   32'h0000_0007);
		send_cmd(OP_SET_NOW,    16'd0,      32'h0000_0008);
		send_cmd(OP_SET_TARGET, 16'h8000,   32'h7FFF_FFFF);
		send_cmd(OP_TICK,       16'h5555,   32'h8000_0000); // one ms elapsed, product stays below the cap
		send_cmd(OP_SET_TARGET, 16'd17,     32'h8000_0001);
		send_cmd(OP_TICK,       16'hAAAA,   32'h8000_0003);
		send_cmd(OP_SET_NOW,    16'd255,    32'h8000_0004);
		send_cmd(OP_SET_NOW,    16'd256,    32'h8000_0005);

		rates[0] = STEP_RATE_RESET;
		rates[1] = 32'h0000_0001;
		rates[2] = 32'hFFFF_FFFF;
		rates[3] = 32'h0000_8000;
		rates[4] = $urandom_range(32'h0000_0100, 32'h0004_0000);
		rates[5] = 32'h0001_8000;
		clock_ms = 32'h8000_0005;

		for (int s = 0; s < 6; s++) begin
			wait_drained();
			write_rate(rates[s]);
			case (s / 2)
				0: begin send_idle_pct = 32; sink_idle_pct = 55; end
				1: begin send_idle_pct = 55; sink_idle_pct = 32; end
				default: begin send_idle_pct = 0; sink_idle_pct = 0; end
			endcase
			while (items_sent < 21 + (s + 1) * PHASE_ITEMS) begin
				ramp_burst();
				// let the pipe run dry now and then
				if ($urandom_range(0, 14) == 0)
					wait_drained();
			end
		end

		wait_drained();
		$display("Sent %0d commands, checked %0d results, %0d ramp steps (%0d saturated).",
			items_sent, sb.checked, sb.ramp_steps, sb.capped_steps);
		$display("Six step rates from 1/65536 to full scale, three idle patterns on both sides.");
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
